// ----- src/obbt_pkg.sv -----
// obbt_pkg: shared widths and types for the oriented box overlap tester
// used by obbt_sep_check and obb_overlap_test_core; depends on nothing
`default_nettype none
package obbt_pkg;
   localparam int LaneW   = 20;
   localparam int FieldW  = 3 * LaneW;
   localparam int NFields = 10;
   localparam int ReqW    = FieldW * NFields;
   localparam int RspW    = 8;
   localparam int FracW   = 18;
   localparam int AccW    = 48;

   typedef logic signed [LaneW-1:0] lane_type;
   typedef logic signed [AccW-1:0]  acc_type;
endpackage
`default_nettype wire

// ----- src/obbt_sep_check.sv -----
// obbt_sep_check: one separating axis compare, |proj| > ra + rb
// depends on obbt_pkg
`default_nettype none
module obbt_sep_check (
   input  wire obbt_pkg::acc_type proj,
   input  wire obbt_pkg::acc_type ra,
   input  wire obbt_pkg::acc_type rb,
   output logic                   sep
);
   logic signed [obbt_pkg::AccW:0] mag_w;
   logic signed [obbt_pkg::AccW:0] rsum_w;

   always_comb begin
      mag_w  = proj[obbt_pkg::AccW-1] ? -{proj[obbt_pkg::AccW-1], proj}
                                       : {proj[obbt_pkg::AccW-1], proj};
      rsum_w = {ra[obbt_pkg::AccW-1], ra} + {rb[obbt_pkg::AccW-1], rb};
      sep    = mag_w > rsum_w;
   end
endmodule
`default_nettype wire

// ----- src/obb_overlap_test_core.sv -----
// obb_overlap_test_core: pipelined 15-axis oriented box overlap tester
// depends on obbt_pkg and obbt_sep_check
//
// usage:
//   req channel carries one box pair per request; req_tdata holds ten
//   60-bit fields, each three 20-bit lanes x,y,z from the lowest bit.
//   rsp channel returns one byte per request, bit 0 = boxes_overlap.
//   rsp_tvalid rises once the request has passed every stage register,
//   and one request is taken every cycle while the receiver keeps up.
//   stages: center difference, rotation and offset products, sums with
//   floor shift, radius and projection products, axis compares.
//   each stage has its own valid bit and holds while the stage after it
//   is full and stalled, so a stall of rsp_tready fills bubbles first
//   and then backs up to req_tready; nothing is lost or repeated.
//   synchronous reset clears all valid bits; the data registers are not reset.
`default_nettype none
module obb_overlap_test_core (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   // center_a, half_extent_a, axis_a_row0..2, center_b, half_extent_b,
   // axis_b_row0..2 (60 bits each, lowest first)
   input  wire  [obbt_pkg::ReqW-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   // boxes_overlap, then zero fill
   output logic [obbt_pkg::RspW-1:0]  rsp_tdata
);
   logic [5:1] vld_ff;
   logic [6:1] en;

   always_comb begin
      en[6] = rsp_tready;
      for (int s = 5; s >= 1; s--) en[s] = !vld_ff[s] || en[s+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[1]) vld_ff[1] <= req_tvalid;
         for (int s = 2; s <= 5; s++) if (en[s]) vld_ff[s] <= vld_ff[s-1];
      end
   end

   assign req_tready = en[1];
   assign rsp_tvalid = vld_ff[5];

   // input unpack
   obbt_pkg::lane_type in_ca[3], in_a[3], in_cb[3], in_b[3];
   obbt_pkg::lane_type in_ma[3][3], in_mb[3][3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         in_ca[k] = req_tdata[0*obbt_pkg::FieldW + 20*k +: 20];
         in_a[k]  = req_tdata[1*obbt_pkg::FieldW + 20*k +: 20];
         in_cb[k] = req_tdata[5*obbt_pkg::FieldW + 20*k +: 20];
         in_b[k]  = req_tdata[6*obbt_pkg::FieldW + 20*k +: 20];
         for (int i = 0; i < 3; i++) begin
            in_ma[i][k] = req_tdata[(2+i)*obbt_pkg::FieldW + 20*k +: 20];
            in_mb[i][k] = req_tdata[(7+i)*obbt_pkg::FieldW + 20*k +: 20];
         end
      end
   end

   // stage 1: center difference
   logic signed [20:0] s1_v_ff[3];
   obbt_pkg::lane_type s1_a_ff[3], s1_b_ff[3], s1_ma_ff[3][3], s1_mb_ff[3][3];

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int k = 0; k < 3; k++) begin
            s1_v_ff[k] <= {in_cb[k][19], in_cb[k]} - {in_ca[k][19], in_ca[k]};
            s1_a_ff[k] <= in_a[k];
            s1_b_ff[k] <= in_b[k];
            for (int i = 0; i < 3; i++) begin
               s1_ma_ff[i][k] <= in_ma[i][k];
               s1_mb_ff[i][k] <= in_mb[i][k];
            end
         end
      end
   end

   // stage 2: offset and rotation products
   logic signed [40:0] s2_pt_ff[3][3];
   logic signed [39:0] s2_pr_ff[3][3][3];
   obbt_pkg::lane_type s2_a_ff[3], s2_b_ff[3];

   always_ff @(posedge clock) begin
      if (en[2]) begin
         for (int i = 0; i < 3; i++) begin
            s2_a_ff[i] <= s1_a_ff[i];
            s2_b_ff[i] <= s1_b_ff[i];
            for (int k = 0; k < 3; k++) begin
               s2_pt_ff[i][k] <= s1_ma_ff[i][k] * s1_v_ff[k];
               for (int j = 0; j < 3; j++)
                  s2_pr_ff[i][j][k] <= s1_ma_ff[i][k] * s1_mb_ff[j][k];
            end
         end
      end
   end

   // stage 3: dot sums, floor to Q.0 / Q.18
   logic signed [42:0] t_sum[3];
   logic signed [41:0] r_sum[3][3];
   logic signed [22:0] r_val[3][3];
   logic signed [22:0] r_mag[3][3];
   logic signed [23:0] s3_t_ff[3];
   logic signed [22:0] s3_r_ff[3][3];
   logic        [21:0] s3_ar_ff[3][3];
   obbt_pkg::lane_type s3_a_ff[3], s3_b_ff[3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         t_sum[i] = 43'(s2_pt_ff[i][0]) + 43'(s2_pt_ff[i][1]) + 43'(s2_pt_ff[i][2]);
         for (int j = 0; j < 3; j++) begin
            r_sum[i][j] = 42'(s2_pr_ff[i][j][0]) + 42'(s2_pr_ff[i][j][1])
                        + 42'(s2_pr_ff[i][j][2]);
            r_val[i][j] = r_sum[i][j][40:obbt_pkg::FracW];
            r_mag[i][j] = r_val[i][j][22] ? -r_val[i][j] : r_val[i][j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         for (int i = 0; i < 3; i++) begin
            s3_a_ff[i] <= s2_a_ff[i];
            s3_b_ff[i] <= s2_b_ff[i];
            s3_t_ff[i] <= t_sum[i][41:obbt_pkg::FracW];
            for (int j = 0; j < 3; j++) begin
               s3_r_ff[i][j]  <= r_val[i][j];
               s3_ar_ff[i][j] <= r_mag[i][j][21:0];
            end
         end
      end
   end

   // stage 4: radius and projection products
   logic signed [42:0] s4_aar_ff[3][3][3];  // a[x] * |R[y][j]|
   logic signed [42:0] s4_bar_ff[3][3][3];  // b[x] * |R[i][y]|
   logic signed [46:0] s4_tr_ff[3][3][3];   // T[x] * R[y][j]
   logic signed [23:0] s4_t_ff[3];
   obbt_pkg::lane_type s4_a_ff[3], s4_b_ff[3];

   always_ff @(posedge clock) begin
      if (en[4]) begin
         for (int x = 0; x < 3; x++) begin
            s4_t_ff[x] <= s3_t_ff[x];
            s4_a_ff[x] <= s3_a_ff[x];
            s4_b_ff[x] <= s3_b_ff[x];
            for (int y = 0; y < 3; y++) begin
               for (int j = 0; j < 3; j++) begin
                  s4_aar_ff[x][y][j] <= s3_a_ff[x] * $signed({1'b0, s3_ar_ff[y][j]});
                  s4_bar_ff[j][x][y] <= s3_b_ff[x] * $signed({1'b0, s3_ar_ff[j][y]});
                  s4_tr_ff[x][y][j]  <= s3_t_ff[x] * s3_r_ff[y][j];
               end
            end
         end
      end
   end

   // stage 5: axis compares
   obbt_pkg::acc_type proj[15], ra[15], rb[15];
   logic [14:0] sep;
   logic        s5_overlap_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         // face axes of a
         proj[i] = {{6{s4_t_ff[i][23]}}, s4_t_ff[i], {obbt_pkg::FracW{1'b0}}};
         ra[i]   = {{10{s4_a_ff[i][19]}}, s4_a_ff[i], {obbt_pkg::FracW{1'b0}}};
         rb[i]   = 48'(s4_bar_ff[i][0][0]) + 48'(s4_bar_ff[i][1][1])
                 + 48'(s4_bar_ff[i][2][2]);
         // face axes of b
         proj[3+i] = 48'(s4_tr_ff[0][0][i]) + 48'(s4_tr_ff[1][1][i])
                   + 48'(s4_tr_ff[2][2][i]);
         ra[3+i]   = 48'(s4_aar_ff[0][0][i]) + 48'(s4_aar_ff[1][1][i])
                   + 48'(s4_aar_ff[2][2][i]);
         rb[3+i]   = {{10{s4_b_ff[i][19]}}, s4_b_ff[i], {obbt_pkg::FracW{1'b0}}};
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            proj[6+3*i+j] = 48'(s4_tr_ff[(i+2)%3][(i+1)%3][j])
                          - 48'(s4_tr_ff[(i+1)%3][(i+2)%3][j]);
            ra[6+3*i+j]   = 48'(s4_aar_ff[(i+1)%3][(i+2)%3][j])
                          + 48'(s4_aar_ff[(i+2)%3][(i+1)%3][j]);
            rb[6+3*i+j]   = 48'(s4_bar_ff[i][(j+1)%3][(j+2)%3])
                          + 48'(s4_bar_ff[i][(j+2)%3][(j+1)%3]);
         end
      end
   end

   for (genvar g = 0; g < 15; g++) begin : g_axis
      obbt_sep_check u_chk (
         .proj (proj[g]),
         .ra   (ra[g]),
         .rb   (rb[g]),
         .sep  (sep[g])
      );
   end

   always_ff @(posedge clock) begin
      if (en[5]) s5_overlap_ff <= ~|sep;
   end

   assign rsp_tdata = {{(obbt_pkg::RspW-1){1'b0}}, s5_overlap_ff};
endmodule
`default_nettype wire

// ----- sim/obbt_checker.sv -----
// obbt_checker: watches the request and response streams of the box overlap
// tester, predicts each overlap flag and compares; depends on obbt_pkg
`timescale 1ns / 100ps
`default_nettype none
module obbt_checker (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   input  wire                        req_tready,
   input  wire [obbt_pkg::ReqW-1:0]   req_tdata,
   input  wire                        rsp_tvalid,
   input  wire                        rsp_tready,
   input  wire [obbt_pkg::RspW-1:0]   rsp_tdata,
   output int                         fail_count,
   output int                         pending
);
   typedef logic signed [63:0] wide_type;

   logic [obbt_pkg::RspW-1:0] flag_queue[$];

   function automatic wide_type lane_of(logic [obbt_pkg::ReqW-1:0] d, int f, int k);
      logic signed [obbt_pkg::LaneW-1:0] l;
      l = d[f*obbt_pkg::FieldW + k*obbt_pkg::LaneW +: obbt_pkg::LaneW];
      return wide_type'(l);
   endfunction

   function automatic wide_type clamp48(wide_type x);
      wide_type hi, lo;
      hi = (64'sd1 <<< 47) - 1;
      lo = -(64'sd1 <<< 47);
      if (x > hi) return hi;
      if (x < lo) return lo;
      return x;
   endfunction

   function automatic wide_type absv(wide_type x);
      return x < 0 ? -x : x;
   endfunction

   // floor divide by 2^18 equals arithmetic right shift
   function automatic wide_type drop_frac(wide_type x);
      return x >>> obbt_pkg::FracW;
   endfunction

   function automatic logic [obbt_pkg::RspW-1:0] overlap_flag(logic [obbt_pkg::ReqW-1:0] d);
      wide_type ca[3], cb[3], ea[3], eb[3], ra_m[3][3], rb_m[3][3];
      wide_type dv[3], tp[3], rot[3][3], arot[3][3];
      wide_type rad_a, rad_b, proj, s;
      int i1, i2, j1, j2;
      logic sep;
      sep = 1'b0;
      for (int k = 0; k < 3; k++) begin
         ca[k] = lane_of(d, 0, k);
         ea[k] = lane_of(d, 1, k);
         cb[k] = lane_of(d, 5, k);
         eb[k] = lane_of(d, 6, k);
         for (int i = 0; i < 3; i++) begin
            ra_m[i][k] = lane_of(d, 2 + i, k);
            rb_m[i][k] = lane_of(d, 7 + i, k);
         end
      end
      for (int k = 0; k < 3; k++) dv[k] = cb[k] - ca[k];
      for (int i = 0; i < 3; i++) begin
         s = 0;
         for (int k = 0; k < 3; k++) s = clamp48(s + ra_m[i][k] * dv[k]);
         tp[i] = drop_frac(s);
         for (int j = 0; j < 3; j++) begin
            s = 0;
            for (int k = 0; k < 3; k++) s = clamp48(s + ra_m[i][k] * rb_m[j][k]);
            rot[i][j] = drop_frac(s);
            arot[i][j] = absv(rot[i][j]);
         end
      end
      for (int i = 0; i < 3; i++) begin
         rad_a = ea[i] <<< obbt_pkg::FracW;
         rad_b = 0;
         for (int k = 0; k < 3; k++) rad_b = clamp48(rad_b + eb[k] * arot[i][k]);
         proj = absv(clamp48(tp[i] <<< obbt_pkg::FracW));
         if (proj > clamp48(rad_a + rad_b)) sep = 1'b1;
      end
      for (int j = 0; j < 3; j++) begin
         rad_a = 0;
         s = 0;
         for (int k = 0; k < 3; k++) begin
            rad_a = clamp48(rad_a + ea[k] * arot[k][j]);
            s = clamp48(s + tp[k] * rot[k][j]);
         end
         rad_b = eb[j] <<< obbt_pkg::FracW;
         if (absv(s) > clamp48(rad_a + rad_b)) sep = 1'b1;
      end
      for (int i = 0; i < 3; i++) begin
         i1 = (i + 1) % 3;
         i2 = (i + 2) % 3;
         for (int j = 0; j < 3; j++) begin
            j1 = (j + 1) % 3;
            j2 = (j + 2) % 3;
            rad_a = clamp48(ea[i1] * arot[i2][j] + ea[i2] * arot[i1][j]);
            rad_b = clamp48(eb[j1] * arot[i][j2] + eb[j2] * arot[i][j1]);
            proj = absv(clamp48(tp[i2] * rot[i1][j] - tp[i1] * rot[i2][j]));
            if (proj > clamp48(rad_a + rad_b)) sep = 1'b1;
         end
      end
      return {{(obbt_pkg::RspW-1){1'b0}}, ~sep};
   endfunction

   logic [obbt_pkg::RspW-1:0] want;

   always @(posedge clock) begin
      if (reset) begin
         fail_count <= 0;
         pending <= 0;
         flag_queue.delete();
      end else begin
         if (req_tvalid && req_tready) flag_queue.push_back(overlap_flag(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (flag_queue.size() == 0) begin
               $display("%0t: unexpected response, expected none actual %h",
                        $time, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = flag_queue.pop_front();
               if (rsp_tdata !== want) begin
                  $display("%0t: overlap flag expected %h actual %h", $time, want, rsp_tdata);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= flag_queue.size();
      end
   end
endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// tb: stimulus and verdict for obb_overlap_test_core
// depends on obbt_pkg, obb_overlap_test_core and obbt_checker
`timescale 1ns / 100ps
`default_nettype none
module tb;
   localparam int RandomPairs = 1450;
   localparam int IdleLimit   = 5000;
   localparam logic [obbt_pkg::LaneW-1:0] QOne = 20'h40000;  // 1.0 in Q1.18

   logic                        clock, reset;
   logic                        req_tvalid, req_tready;
   logic [obbt_pkg::ReqW-1:0]   req_tdata;
   logic                        rsp_tvalid, rsp_tready;
   logic [obbt_pkg::RspW-1:0]   rsp_tdata;
   int                          fail_count, pending;
   logic                        hold_rsp;
   logic                        hold_done;
   int                          idle_cycles;

   obb_overlap_test_core DUT (.*);

   obbt_checker u_check (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [obbt_pkg::FieldW-1:0] pack3(logic [obbt_pkg::LaneW-1:0] x,
                                                         logic [obbt_pkg::LaneW-1:0] y,
                                                         logic [obbt_pkg::LaneW-1:0] z);
      return {z, y, x};
   endfunction

   function automatic logic [obbt_pkg::FieldW-1:0] rand_field();
      return obbt_pkg::FieldW'({$urandom(), $urandom()});
   endfunction

   function automatic logic [obbt_pkg::ReqW-1:0] rand_req();
      return {rand_field(), rand_field(), rand_field(), rand_field(), rand_field(),
              rand_field(), rand_field(), rand_field(), rand_field(), rand_field()};
   endfunction

   function automatic logic [obbt_pkg::LaneW-1:0] rand_lane(int span);
      int v;
      v = int'($urandom_range(2 * span, 0)) - span;
      return obbt_pkg::LaneW'(v);
   endfunction

   // a plausible box pair: identity-ish rotations with small jitter, non-negative extents
   function automatic logic [obbt_pkg::ReqW-1:0] box_pair(int spread);
      logic [obbt_pkg::ReqW-1:0] d;
      for (int b = 0; b < 2; b++) begin
         d[(5*b)*obbt_pkg::FieldW +: obbt_pkg::FieldW] = pack3(rand_lane(spread),
               rand_lane(spread), rand_lane(spread));
         d[(5*b+1)*obbt_pkg::FieldW +: obbt_pkg::FieldW] = pack3(
               obbt_pkg::LaneW'($urandom_range(spread, 0)),
               obbt_pkg::LaneW'($urandom_range(spread, 0)),
               obbt_pkg::LaneW'($urandom_range(spread, 0)));
         for (int r = 0; r < 3; r++)
            d[(5*b+2+r)*obbt_pkg::FieldW +: obbt_pkg::FieldW] = pack3(
                  (r == 0 ? QOne : 20'h0) + rand_lane(40000),
                  (r == 1 ? QOne : 20'h0) + rand_lane(40000),
                  (r == 2 ? QOne : 20'h0) + rand_lane(40000));
      end
      return d;
   endfunction

   function automatic logic [obbt_pkg::ReqW-1:0] all_fields(logic [obbt_pkg::FieldW-1:0] f);
      return {obbt_pkg::NFields{f}};
   endfunction

   task automatic send(logic [obbt_pkg::ReqW-1:0] d);
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic gap();
      req_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clock);
   endtask

   logic [obbt_pkg::ReqW-1:0] ident, d;
   int burst;

   // receiver stall pattern plus one long hold-off
   initial begin
      rsp_tready = 1'b0;
      hold_done = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp && !hold_done) begin
            // long hold-off so the pipeline fills and backs up to the request side
            rsp_tready <= 1'b0;
            repeat (200) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(3, 0) != 0) || ($time / 5000) % 3 == 0;
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      hold_rsp = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      ident = '0;
      for (int b = 0; b < 2; b++) begin
         ident[(5*b+1)*obbt_pkg::FieldW +: obbt_pkg::FieldW] = pack3(20'h100, 20'h100, 20'h100);
         ident[(5*b+2)*obbt_pkg::FieldW +: obbt_pkg::FieldW] = pack3(QOne, '0, '0);
         ident[(5*b+3)*obbt_pkg::FieldW +: obbt_pkg::FieldW] = pack3('0, QOne, '0);
         ident[(5*b+4)*obbt_pkg::FieldW +: obbt_pkg::FieldW] = pack3('0, '0, QOne);
      end
      // coincident, touching along x, just apart, far apart
      send(ident);
      d = ident; d[5*obbt_pkg::FieldW +: obbt_pkg::FieldW] = pack3(20'h200, '0, '0); send(d);
      d = ident; d[5*obbt_pkg::FieldW +: obbt_pkg::FieldW] = pack3(20'h201, '0, '0); send(d);
      d = ident;
      d[5*obbt_pkg::FieldW +: obbt_pkg::FieldW] = pack3(20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
      d[0 +: obbt_pkg::FieldW] = pack3(20'h80000, 20'h80000, 20'h80000); send(d);
      // negative extents
      d = ident;
      d[obbt_pkg::FieldW +: obbt_pkg::FieldW] = pack3(20'hFFF00, 20'hFFF00, 20'hFFF00);
      send(d);
      // extremes of every field
      send(all_fields('0));
      send(all_fields('1));
      send(all_fields({3{20'h7FFFF}}));
      send(all_fields({3{20'h80000}}));
      send(all_fields({3{20'h80000}}) ^ {obbt_pkg::ReqW/2{2'b01}});
      send({obbt_pkg::ReqW/2{2'b10}});
      // skewed, non-orthonormal rows
      d = ident; d[7*obbt_pkg::FieldW +: obbt_pkg::FieldW] = pack3(QOne, QOne, QOne);
      d[5*obbt_pkg::FieldW +: obbt_pkg::FieldW] = pack3(20'h180, 20'h180, '0); send(d);
      for (int n = 0; n < 8; n++) send(box_pair(1024));
      req_tvalid <= 1'b0;
      // drain fully before the random part
      @(negedge clock);
      while (pending != 0) @(negedge clock);

      for (int n = 0; n < RandomPairs; ) begin
         burst = $urandom_range(40, 1);
         for (int m = 0; m < burst && n < RandomPairs; m++, n++) begin
            if (n == 400) hold_rsp = 1'b1;
            if (n == 900) begin
               req_tvalid <= 1'b0;
               while (pending != 0) @(negedge clock);
            end
            case ($urandom_range(9, 0))
               0:       send(rand_req());
               1:       send(box_pair(200000));
               default: send(box_pair($urandom_range(3000, 50)));
            endcase
         end
         if ($urandom_range(3, 0) == 0) gap();
      end
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end
endmodule
`default_nettype wire

// ----- files.f -----
src/obbt_pkg.sv
src/obbt_sep_check.sv
src/obb_overlap_test_core.sv
sim/obbt_checker.sv
sim/tb.sv
